// ----- rtl/mlqs_pkg.sv -----
// shared types and codes for the multilevel queue slot scheduler
// used by the controller, the datapath and the top level; no dependencies
package mlqs_pkg;

	localparam int CMD_W   = 1;
	localparam int ID_W    = 8;
	localparam int LEVEL_W = 3;

	localparam logic [CMD_W-1:0] CMD_PUT = 1'b0;
	localparam logic [CMD_W-1:0] CMD_GET = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the accepted transaction
		logic decode;    // put: write or drop; get: refill and mark eligible levels
		logic pick;      // select the lowest eligible level
		logic read;      // read the head entry and update level bookkeeping
		logic load_out;  // move the result into the output register
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_get;
	} dp_status_t;

endpackage

// ----- rtl/mlqs_ctrl.sv -----
// controller state machine of the multilevel queue slot scheduler
// depends on mlqs_pkg for the command and status structs
module mlqs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  mlqs_pkg::dp_status_t  status,
	output mlqs_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_PICK   = 5'b00100,
		ST_READ   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = status.is_get ? ST_PICK : ST_DONE;
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_d  = ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				// hold the result until the output register is free
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/mlqs_datapath.sv -----
// datapath of the multilevel queue slot scheduler: level fifo memory,
// per-level head, count and slot registers, level select and output register
// depends on mlqs_pkg for field widths, command codes and control structs
module mlqs_datapath #(
	parameter int NUM_LEVELS  = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [mlqs_pkg::CMD_W-1:0]     in_cmd,
	input  logic [mlqs_pkg::ID_W-1:0]      in_proc_id,
	input  logic [mlqs_pkg::LEVEL_W-1:0]   in_prio_level,
	input  mlqs_pkg::ctrl_cmd_t            cmd,
	output mlqs_pkg::dp_status_t           status,
	output logic                           proc_valid,
	output logic [mlqs_pkg::ID_W-1:0]      out_proc_id,
	output logic [mlqs_pkg::LEVEL_W-1:0]   served_level,
	output logic                           dropped
);

	localparam int LW = $clog2(NUM_LEVELS);
	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = $clog2(NUM_LEVELS + 1);
	localparam int TW = IW + 1;
	localparam int AW = $clog2(NUM_LEVELS * QUEUE_DEPTH);
	localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;

	logic [mlqs_pkg::ID_W-1:0] mem [MEM_DEPTH];

	logic [mlqs_pkg::CMD_W-1:0]   cmd_q;
	logic [mlqs_pkg::ID_W-1:0]    id_q;
	logic [mlqs_pkg::LEVEL_W-1:0] lvl_q;

	logic [IW-1:0] head_q  [NUM_LEVELS];
	logic [CW-1:0] count_q [NUM_LEVELS];
	logic [SW-1:0] slots_q [NUM_LEVELS];

	logic [NUM_LEVELS-1:0] elig_q;
	logic [LW-1:0]         sel_q;
	logic                  found_q;
	logic                  drop_q;
	logic [mlqs_pkg::ID_W-1:0] rd_data_q;

	logic                  is_get;
	logic                  in_range;
	logic [LW-1:0]         lvl_idx;
	logic [IW-1:0]         put_head;
	logic [CW-1:0]         put_count;
	logic [TW-1:0]         tail_sum;
	logic [IW-1:0]         tail_idx;
	logic                  put_full;
	logic                  drop_now;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic [IW-1:0]         sel_head;
	logic                  slots_spent;
	logic [NUM_LEVELS-1:0] elig_d;
	logic [LW-1:0]         pick_lvl;
	logic                  pick_found;

	assign is_get        = (cmd_q == mlqs_pkg::CMD_GET);
	assign status.is_get = is_get;

	// put path: tail position of the addressed level
	assign in_range  = (int'(lvl_q) < NUM_LEVELS);
	assign lvl_idx   = LW'(lvl_q);
	assign put_head  = head_q[lvl_idx];
	assign put_count = count_q[lvl_idx];
	assign tail_sum  = TW'(put_head) + TW'(put_count);
	assign tail_idx  = (tail_sum >= TW'(QUEUE_DEPTH)) ? IW'(tail_sum - TW'(QUEUE_DEPTH))
	                                                   : IW'(tail_sum);
	assign put_full  = (put_count >= CW'(QUEUE_DEPTH));
	assign drop_now  = !in_range || put_full;
	assign wr_en     = cmd.decode && !is_get && !drop_now;
	assign wr_addr   = AW'(lvl_idx) * AW'(QUEUE_DEPTH) + AW'(tail_idx);

	// get path: quota refill test and eligible levels after refill
	always_comb begin
		slots_spent = 1'b1;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (slots_q[i] != '0) begin
				slots_spent = 1'b0;
			end
		end
		for (int i = 0; i < NUM_LEVELS; i++) begin
			elig_d[i] = (slots_spent || (slots_q[i] != '0)) && (count_q[i] != '0);
		end
	end

	// lowest-index eligible level wins
	always_comb begin
		pick_lvl   = '0;
		pick_found = 1'b0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (elig_q[i]) begin
				pick_lvl   = LW'(i);
				pick_found = 1'b1;
			end
		end
	end

	assign sel_head = head_q[sel_q];
	assign rd_addr  = AW'(sel_q) * AW'(QUEUE_DEPTH) + AW'(sel_head);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= in_cmd;
			id_q  <= in_proc_id;
			lvl_q <= in_prio_level;
		end
		if (cmd.decode) begin
			drop_q <= drop_now;
			elig_q <= elig_d;
		end
		if (cmd.pick) begin
			sel_q   <= pick_lvl;
			found_q <= pick_found;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= id_q;
		end
		if (cmd.read && found_q) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
				slots_q[i] <= SW'(NUM_LEVELS - i);
			end
		end else begin
			if (wr_en) begin
				count_q[lvl_idx] <= put_count + 1'b1;
			end
			if (cmd.decode && is_get && slots_spent) begin
				for (int i = 0; i < NUM_LEVELS; i++) begin
					slots_q[i] <= SW'(NUM_LEVELS - i);
				end
			end
			if (cmd.read && found_q) begin
				head_q[sel_q]  <= (sel_head == IW'(QUEUE_DEPTH - 1)) ? '0 : sel_head + 1'b1;
				count_q[sel_q] <= count_q[sel_q] - 1'b1;
				slots_q[sel_q] <= slots_q[sel_q] - 1'b1;
			end
		end
	end

	// output register, held while the result transaction waits
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			proc_valid   <= is_get && found_q;
			out_proc_id  <= (is_get && found_q) ? rd_data_q : '0;
			served_level <= (is_get && found_q) ? mlqs_pkg::LEVEL_W'(sel_q) : '0;
			dropped      <= !is_get && drop_q;
		end
	end

endmodule

// ----- rtl/multilevel_queue_slot_scheduler.sv -----
// Multilevel queue scheduler with a per-level slot quota. Each transaction
// is a put (append proc_id to the fifo of prio_level, dropped when full or
// when the level does not exist) or a get (refill all slot counters when
// every one is zero, then serve the lowest level with slots left and work
// queued). One transaction is in work at a time: a put passes the decode
// and done states, a get also the pick and read states of the registered
// level scan and fifo memory read. The output register lets a new
// transaction be accepted while a result still waits on out_ready.
// The fifo memory holds NUM_LEVELS * QUEUE_DEPTH entries and needs no clear.
// depends on mlqs_pkg, mlqs_ctrl and mlqs_datapath
module multilevel_queue_slot_scheduler #(
	parameter int NUM_LEVELS  = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mlqs_pkg::CMD_W-1:0]    cmd,
	input  logic [mlqs_pkg::ID_W-1:0]     proc_id,
	input  logic [mlqs_pkg::LEVEL_W-1:0]  prio_level,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          proc_valid,
	output logic [mlqs_pkg::ID_W-1:0]     out_proc_id,
	output logic [mlqs_pkg::LEVEL_W-1:0]  served_level,
	output logic                          dropped
);

	mlqs_pkg::ctrl_cmd_t  ctrl_cmd;
	mlqs_pkg::dp_status_t dp_status;

	mlqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (dp_status),
		.cmd       (ctrl_cmd)
	);

	mlqs_datapath #(
		.NUM_LEVELS  (NUM_LEVELS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_cmd        (cmd),
		.in_proc_id    (proc_id),
		.in_prio_level (prio_level),
		.cmd           (ctrl_cmd),
		.status        (dp_status),
		.proc_valid    (proc_valid),
		.out_proc_id   (out_proc_id),
		.served_level  (served_level),
		.dropped       (dropped)
	);

endmodule

// ----- test/multilevel_queue_slot_scheduler_tb.sv -----
// testbench for multilevel_queue_slot_scheduler: directed rows, then random put/get traffic
// checked against an in-bench scheduler model; depends on mlqs_pkg and the rtl top level
module multilevel_queue_slot_scheduler_tb;

	localparam int NL              = 8;
	localparam int QD              = 16;
	localparam int HOLD_CYCLES     = 300;
	localparam int STALL_LIMIT     = 4000;
	localparam int ITEMS_PER_PHASE = 410;
	localparam int SETTLE_CYCLES   = 20;

	typedef struct packed {
		logic                         proc_valid;
		logic [mlqs_pkg::ID_W-1:0]    proc_id;
		logic [mlqs_pkg::LEVEL_W-1:0] level;
		logic                         dropped;
	} sched_result_t;

	typedef struct {
		logic [mlqs_pkg::CMD_W-1:0]   cmd;
		logic [mlqs_pkg::ID_W-1:0]    proc_id;
		logic [mlqs_pkg::LEVEL_W-1:0] level;
		bit                           typed;
		sched_result_t                want;
	} stim_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [mlqs_pkg::CMD_W-1:0]   cmd;
	logic [mlqs_pkg::ID_W-1:0]    proc_id;
	logic [mlqs_pkg::LEVEL_W-1:0] prio_level;
	logic                         out_valid;
	logic                         out_ready;
	logic                         proc_valid;
	logic [mlqs_pkg::ID_W-1:0]    out_proc_id;
	logic [mlqs_pkg::LEVEL_W-1:0] served_level;
	logic                         dropped;

	// model state of the scheduler
	logic [mlqs_pkg::ID_W-1:0] lvl_mem   [NL][QD];
	logic [3:0]                lvl_head  [NL];
	logic [4:0]                lvl_count [NL];
	logic [3:0]                lvl_slots [NL];

	sched_result_t results_due[$];
	stim_row_t     directed_rows[$];
	int            mismatches      = 0;
	int            idle_cycles     = 0;
	int            sender_idle_pct = 0;
	int            stall_pct       = 0;
	bit            hold_req        = 1'b0;

	multilevel_queue_slot_scheduler #(
		.NUM_LEVELS  (NL),
		.QUEUE_DEPTH (QD)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.proc_id      (proc_id),
		.prio_level   (prio_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.proc_valid   (proc_valid),
		.out_proc_id  (out_proc_id),
		.served_level (served_level),
		.dropped      (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void refill_slots();
		for (int i = 0; i < NL; i++)
			lvl_slots[i] = 4'(NL - i);
	endfunction

	function automatic sched_result_t schedule_item(input logic [mlqs_pkg::CMD_W-1:0] c,
			input logic [mlqs_pkg::ID_W-1:0] id, input logic [mlqs_pkg::LEVEL_W-1:0] lv);
		sched_result_t r;
		bit any_left;
		int sel;
		r = '0;
		if (c == mlqs_pkg::CMD_PUT) begin
			if (int'(lv) >= NL)
				r.dropped = 1'b1;
			else if (int'(lvl_count[lv]) >= QD)
				r.dropped = 1'b1;
			else begin
				lvl_mem[lv][(int'(lvl_head[lv]) + int'(lvl_count[lv])) % QD] = id;
				lvl_count[lv] = lvl_count[lv] + 5'd1;
			end
		end else begin
			any_left = 1'b0;
			for (int i = 0; i < NL; i++)
				if (lvl_slots[i] != 0)
					any_left = 1'b1;
			if (!any_left)
				refill_slots();
			sel = -1;
			for (int i = 0; i < NL; i++)
				if (sel < 0 && lvl_slots[i] != 0 && lvl_count[i] != 0)
					sel = i;
			if (sel >= 0) begin
				r.proc_valid     = 1'b1;
				r.proc_id        = lvl_mem[sel][lvl_head[sel]];
				r.level          = mlqs_pkg::LEVEL_W'(sel);
				lvl_head[sel]    = 4'((int'(lvl_head[sel]) + 1) % QD);
				lvl_count[sel]   = lvl_count[sel] - 5'd1;
				lvl_slots[sel]   = lvl_slots[sel] - 4'd1;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("tb: mismatch on %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic add_row(input logic [mlqs_pkg::CMD_W-1:0] c,
			input logic [mlqs_pkg::ID_W-1:0] id,
			input logic [mlqs_pkg::LEVEL_W-1:0] lv, input bit typed = 1'b0,
			input sched_result_t want = '0);
		stim_row_t row;
		row.cmd     = c;
		row.proc_id = id;
		row.level   = lv;
		row.typed   = typed;
		row.want    = want;
		directed_rows.push_back(row);
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic offer_item(input logic [mlqs_pkg::CMD_W-1:0] c,
			input logic [mlqs_pkg::ID_W-1:0] id,
			input logic [mlqs_pkg::LEVEL_W-1:0] lv, input bit typed = 1'b0,
			input sched_result_t want = '0);
		sched_result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		proc_id    <= id;
		prio_level <= lv;
		do @(posedge clk); while (!in_ready);
		predicted = schedule_item(c, id, lv);
		results_due.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
	endtask

	// receiver side
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n)
				out_ready <= 1'b0;
			else if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0)
				report_mismatch("unexpected transaction", 8'h00, 8'h00);
			else begin
				want = results_due.pop_front();
				if (proc_valid !== want.proc_valid)
					report_mismatch("proc_valid", 8'(proc_valid), 8'(want.proc_valid));
				if (out_proc_id !== want.proc_id)
					report_mismatch("out_proc_id", out_proc_id, want.proc_id);
				if (served_level !== want.level)
					report_mismatch("served_level", 8'(served_level), 8'(want.level));
				if (dropped !== want.dropped)
					report_mismatch("dropped", 8'(dropped), 8'(want.dropped));
			end
		end
	end

	// watchdog on cycles without any accepted transaction or taken result
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int                           put_pct;
		bit                           narrow;
		logic [mlqs_pkg::LEVEL_W-1:0] lvl_base;
		logic [mlqs_pkg::LEVEL_W-1:0] lv;
		logic [mlqs_pkg::CMD_W-1:0]   c;
		stim_row_t                    row;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cmd        = mlqs_pkg::CMD_PUT;
		proc_id    = '0;
		prio_level = '0;
		for (int i = 0; i < NL; i++) begin
			lvl_head[i]  = '0;
			lvl_count[i] = '0;
		end
		refill_slots();
		put_pct  = 50;
		narrow   = 1'b0;
		lvl_base = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// nothing queued yet
		add_row(mlqs_pkg::CMD_GET, 8'h5A, 3'd2, 1'b1, '0);
		add_row(mlqs_pkg::CMD_PUT, 8'hFF, 3'd7, 1'b1, '0);
		// level 7 has a single slot, spent here
		add_row(mlqs_pkg::CMD_GET, 8'h00, 3'd0, 1'b1, '{1'b1, 8'hFF, 3'd7, 1'b0});
		for (int i = 0; i < QD; i++)
			add_row(mlqs_pkg::CMD_PUT, 8'(i * 17), 3'd7);
		add_row(mlqs_pkg::CMD_PUT, 8'hA5, 3'd7, 1'b1, '{1'b0, 8'h00, 3'd0, 1'b1});
		// level 7 full but out of slots, others still have slots: no refill
		add_row(mlqs_pkg::CMD_GET, 8'hFF, 3'd7, 1'b1, '0);
		add_row(mlqs_pkg::CMD_PUT, 8'h00, 3'd0, 1'b1, '0);
		add_row(mlqs_pkg::CMD_GET, 8'hFF, 3'd7, 1'b1, '{1'b1, 8'h00, 3'd0, 1'b0});

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			offer_item(row.cmd, row.proc_id, row.level, row.typed, row.want);
		end
		drain_results();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 70; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 70; end
				default: begin sender_idle_pct = 19; stall_pct = 19; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// change the traffic mix every few dozen items
				if (n % 40 == 0) begin
					case ($urandom_range(2))
						0: put_pct = 85;
						1: put_pct = 50;
						default: put_pct = 25;
					endcase
					narrow   = ($urandom_range(2) == 0);
					lvl_base = mlqs_pkg::LEVEL_W'($urandom_range(NL - 1));
				end
				// long receiver hold-off while the sender keeps offering
				if (p == 0 && n == 200)
					hold_req = 1'b1;
				lv = narrow ? (lvl_base ^ mlqs_pkg::LEVEL_W'($urandom_range(1)))
					: mlqs_pkg::LEVEL_W'($urandom_range(7));
				c = ($urandom_range(99) < put_pct) ? mlqs_pkg::CMD_PUT : mlqs_pkg::CMD_GET;
				offer_item(c, mlqs_pkg::ID_W'($urandom_range(255)), lv);
			end
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
